>>> src/fcr_pkg.sv
package fcr_pkg;

	localparam int MAX_FRAME_LEN = 10;
	localparam int MIN_FRAME_LEN = 5;
	localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);

	localparam logic [7:0] FIRST_MOTOR_INDEX = 8'h01;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_BYTE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

	localparam logic [7:0] HEAD_BYTE_RESET = 8'hA5;
	localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd100;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SUM = 2'd1;
	localparam logic [1:0] ST_LEN = 2'd2;
	localparam logic [1:0] ST_TIME = 2'd3;

	typedef struct packed {
		logic valid;
		logic [1:0] status;
		logic motor_select;
		logic [7:0] command;
		logic [7:0] first_status;
		logic [7:0] second_status;
	} fcr_result_t;

endpackage

>>> src/fcr_frame_fsm.sv
module fcr_frame_fsm import fcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic mode,
	input logic [7:0] rx_byte,
	input logic [7:0] head_byte,
	input logic [15:0] timeout_ticks,
	output fcr_result_t result
);

	typedef enum logic [2:0] {
		PH_HUNT = 3'b001,
		PH_LEN = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

	phase_t phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] target_q, target_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] index_q, index_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] first_q, first_d;
	logic [7:0] second_q, second_d;
	logic [15:0] idle_q, idle_d;

	logic [15:0] limit;
	logic [15:0] idle_inc;
	logic [CNT_W:0] pos_next;
	logic [1:0] res_status;
	logic res_sel;
	logic [7:0] res_cmd;
	logic res_valid;

	assign limit = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
	assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
	assign pos_next = {1'b0, count_q} + {{CNT_W{1'b0}}, 1'b1};

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		target_d = target_q;
		sum_d = sum_q;
		index_d = index_q;
		cmd_d = cmd_q;
		first_d = first_q;
		second_d = second_q;
		idle_d = idle_q;
		res_valid = 1'b0;
		res_status = ST_OK;
		res_sel = 1'b0;
		res_cmd = 8'd0;
		if (mode == MODE_TICK) begin
			if (phase_q != PH_HUNT) begin
				idle_d = idle_inc;
				if (idle_inc >= limit) begin
					phase_d = PH_HUNT;
					count_d = '0;
					idle_d = 16'd0;
					res_valid = 1'b1;
					res_status = ST_TIME;
				end
			end
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == head_byte) begin
						sum_d = rx_byte;
						count_d = CNT_W'(1);
						phase_d = PH_LEN;
						idle_d = 16'd0;
					end
				end
				PH_LEN: begin
					idle_d = 16'd0;
					if (rx_byte < 8'(MIN_FRAME_LEN) || rx_byte > 8'(MAX_FRAME_LEN)) begin
						phase_d = PH_HUNT;
						count_d = '0;
						res_valid = 1'b1;
						res_status = ST_LEN;
					end else begin
						target_d = rx_byte[CNT_W-1:0];
						sum_d = sum_q + rx_byte;
						count_d = CNT_W'(2);
						phase_d = PH_BODY;
					end
				end
				PH_BODY: begin
					idle_d = 16'd0;
					if (pos_next >= {1'b0, target_q}) begin
						phase_d = PH_HUNT;
						count_d = '0;
						res_valid = 1'b1;
						if (rx_byte != sum_q) begin
							res_status = ST_SUM;
						end else if (index_q == FIRST_MOTOR_INDEX) begin
							first_d = cmd_q;
							res_cmd = cmd_q;
						end else begin
							second_d = cmd_q;
							res_sel = 1'b1;
							res_cmd = cmd_q;
						end
					end else begin
						if (count_q == CNT_W'(2)) begin
							index_d = rx_byte;
						end else if (count_q == CNT_W'(3)) begin
							cmd_d = rx_byte;
						end
						sum_d = sum_q + rx_byte;
						count_d = pos_next[CNT_W-1:0];
					end
				end
				default: begin
					phase_d = PH_HUNT;
					count_d = '0;
				end
			endcase
		end
	end

	assign result.valid = res_valid;
	assign result.status = res_status;
	assign result.motor_select = res_sel;
	assign result.command = res_cmd;
	assign result.first_status = first_d;
	assign result.second_status = second_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			target_q <= '0;
			sum_q <= 8'd0;
			index_q <= 8'd0;
			cmd_q <= 8'd0;
			first_q <= 8'd0;
			second_q <= 8'd0;
			idle_q <= 16'd0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			target_q <= target_d;
			sum_q <= sum_d;
			index_q <= index_d;
			cmd_q <= cmd_d;
			first_q <= first_d;
			second_q <= second_d;
			idle_q <= idle_d;
		end
	end

endmodule

>>> src/framed_command_receiver.sv
// Receives a stream of items, each either a serial byte or a time tick, and
// decodes frames made of a head byte, a total length byte, an index byte, a
// command byte, optional padding and an 8-bit sum checksum as the last byte.
// The input channel is in_valid/in_stall with fields mode and rx_byte; the
// result channel is out_valid/out_stall with status, motor_select, command
// and both stored motor status bytes. A result appears for every completed
// frame and for every aborted frame (checksum, length or idle timeout).
// The configuration port writes the head byte and the timeout in ticks.
// An item is registered in the input register and decoded on its way into
// the output register, from which its result is offered to the receiver.
// One item is accepted per cycle as long as the result side keeps up.
// When the receiver stalls, the pending result is held, one more item can
// sit in the input register, and in_stall rises once that item would need
// the output register. Reset returns the decoder to hunting for a head
// byte, clears both motor status bytes and loads the default registers.
module framed_command_receiver import fcr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic mode,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic motor_select,
	output logic [7:0] command,
	output logic [7:0] first_motor_status,
	output logic [7:0] second_motor_status,
	input logic cfg_write,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	logic [7:0] head_byte_q;
	logic [15:0] timeout_ticks_q;

	logic valid_s1;
	logic mode_s1;
	logic [7:0] byte_s1;

	logic valid_s2;
	fcr_result_t res_s2;

	fcr_result_t res;
	logic out_free;
	logic advance;
	logic step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_byte_q <= HEAD_BYTE_RESET;
			timeout_ticks_q <= TIMEOUT_TICKS_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_HEAD_BYTE: head_byte_q <= cfg_data[7:0];
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign out_free = !valid_s2 || !out_stall;
	assign advance = !valid_s1 || !res.valid || out_free;
	assign step = valid_s1 && advance;
	assign in_stall = !advance;

	fcr_frame_fsm u_fsm (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.mode(mode_s1),
		.rx_byte(byte_s1),
		.head_byte(head_byte_q),
		.timeout_ticks(timeout_ticks_q),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			mode_s1 <= mode;
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && res.valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign status = res_s2.status;
	assign motor_select = res_s2.motor_select;
	assign command = res_s2.command;
	assign first_motor_status = res_s2.first_status;
	assign second_motor_status = res_s2.second_status;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a blocked result");

	a_ok_first: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status == ST_OK && !motor_select |-> command == first_motor_status)
		else $error("first motor status does not hold the accepted command");

	a_ok_second: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status == ST_OK && motor_select |-> command == second_motor_status)
		else $error("second motor status does not hold the accepted command");

	a_abort_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status != ST_OK |-> !motor_select && command == 8'd0)
		else $error("aborted frame reports a command");

endmodule

>>> bench/tb.sv
import fcr_pkg::*;

typedef enum logic [1:0] {HUNTING, AWAIT_LENGTH, IN_BODY} rx_phase_t;

typedef struct packed {
	logic [1:0] status;
	logic motor_select;
	logic [7:0] command;
	logic [7:0] first_motor_status;
	logic [7:0] second_motor_status;
} frame_report_t;

class frame_checker;
	logic [7:0] head;
	logic [15:0] tmo;
	rx_phase_t state;
	logic [7:0] count;
	logic [7:0] target;
	logic [7:0] sum;
	logic [7:0] index_q;
	logic [7:0] command_q;
	logic [7:0] first_q;
	logic [7:0] second_q;
	bit armed;
	logic [15:0] ticks;
	frame_report_t expected_reports[$];
	int unsigned errors;

	function new();
		head = HEAD_BYTE_RESET;
		tmo = TIMEOUT_TICKS_RESET;
		target = 8'h00;
		sum = 8'h00;
		index_q = 8'h00;
		command_q = 8'h00;
		first_q = 8'h00;
		second_q = 8'h00;
		errors = 0;
		to_hunting();
	endfunction

	function void to_hunting();
		state = HUNTING;
		count = 8'h00;
		armed = 1'b0;
		ticks = 16'h0000;
	endfunction

	function void apply_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		if (idx == CFG_HEAD_BYTE) begin
			head = data[7:0];
		end else if (idx == CFG_TIMEOUT_TICKS) begin
			tmo = data;
		end
	endfunction

	function int unsigned pending();
		return expected_reports.size();
	endfunction

	function void expect_report(logic [1:0] st, logic sel, logic [7:0] cmd);
		frame_report_t r;
		r.status = st;
		r.motor_select = sel;
		r.command = cmd;
		r.first_motor_status = first_q;
		r.second_motor_status = second_q;
		expected_reports.push_back(r);
	endfunction

	function void note_item(logic m, logic [7:0] b);
		logic [15:0] limit;
		limit = (tmo == 16'h0000) ? 16'h0001 : tmo;
		if (m == MODE_TICK) begin
			if (state == HUNTING || !armed) begin
				return;
			end
			if (ticks != 16'hFFFF) begin
				ticks++;
			end
			if (ticks >= limit) begin
				to_hunting();
				expect_report(ST_TIME, 1'b0, 8'h00);
			end
			return;
		end
		if (state == HUNTING) begin
			if (b == head) begin
				sum = b;
				count = 8'd1;
				state = AWAIT_LENGTH;
				armed = 1'b1;
				ticks = 16'h0000;
			end
			return;
		end
		ticks = 16'h0000;
		if (state == AWAIT_LENGTH) begin
			if (b < MIN_FRAME_LEN || b > MAX_FRAME_LEN) begin
				to_hunting();
				expect_report(ST_LEN, 1'b0, 8'h00);
				return;
			end
			target = b;
			sum = sum + b;
			count = 8'd2;
			state = IN_BODY;
			return;
		end
		if (int'(count) + 1 >= int'(target)) begin
			to_hunting();
			if (b != sum) begin
				expect_report(ST_SUM, 1'b0, 8'h00);
			end else if (index_q == FIRST_MOTOR_INDEX) begin
				first_q = command_q;
				expect_report(ST_OK, 1'b0, command_q);
			end else begin
				second_q = command_q;
				expect_report(ST_OK, 1'b1, command_q);
			end
			return;
		end
		if (count == 8'd2) begin
			index_q = b;
		end else if (count == 8'd3) begin
			command_q = b;
		end
		sum = sum + b;
		count = count + 8'd1;
	endfunction

	function void compare_field(string name, logic [7:0] exp, logic [7:0] got);
		if (exp !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, exp, got);
			errors++;
		end
	endfunction

	function void check_report(frame_report_t got);
		frame_report_t exp;
		if (expected_reports.size() == 0) begin
			$display("%0t: result with none expected, status %0d command %0h", $time,
				got.status, got.command);
			errors++;
			return;
		end
		exp = expected_reports.pop_front();
		compare_field("status", 8'(exp.status), 8'(got.status));
		compare_field("motor_select", 8'(exp.motor_select), 8'(got.motor_select));
		compare_field("command", exp.command, got.command);
		compare_field("first_motor_status", exp.first_motor_status, got.first_motor_status);
		compare_field("second_motor_status", exp.second_motor_status,
			got.second_motor_status);
	endfunction
endclass

module tb;
	localparam int WATCHDOG_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = MODE_BYTE;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic motor_select;
	logic [7:0] command;
	logic [7:0] first_motor_status;
	logic [7:0] second_motor_status;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_HEAD_BYTE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	frame_checker sb;
	int unsigned burst_left = 0;
	int unsigned quiet = 0;
	int unsigned stall_style = 0;
	int unsigned style_left = 0;

	framed_command_receiver u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.motor_select(motor_select),
		.command(command),
		.first_motor_status(first_motor_status),
		.second_motor_status(second_motor_status),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (style_left == 0) begin
			stall_style = $urandom_range(0, 3);
			style_left = (stall_style == 3) ? $urandom_range(5, 40) : $urandom_range(20, 200);
		end
		style_left--;
		case (stall_style)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 1) == 1);
			2: out_stall <= ($urandom_range(0, 99) < 80);
			default: out_stall <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		frame_report_t seen;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_item(mode, rx_byte);
			end
			if (out_valid && !out_stall) begin
				seen.status = status;
				seen.motor_select = motor_select;
				seen.command = command;
				seen.first_motor_status = first_motor_status;
				seen.second_motor_status = second_motor_status;
				sb.check_report(seen);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("framed_command_receiver: mismatch");
				$finish;
			end
		end
	end

	task automatic send_item(input logic m, input logic [7:0] b);
		int unsigned gap;
		int unsigned pick;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			pick = $urandom_range(0, 9);
			gap = (pick < 4) ? 0 : (pick < 9) ? $urandom_range(1, 4) : $urandom_range(5, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= m;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_ticks(input int unsigned n);
		repeat (n) send_item(MODE_TICK, 8'($urandom));
	endtask

	function automatic int unsigned tick_limit();
		return (sb.tmo == 16'h0000) ? 1 : int'(sb.tmo);
	endfunction

	task automatic send_frame(input int unsigned len, input logic [7:0] idx,
			input logic [7:0] cmd, input bit corrupt, input int unsigned keep);
		logic [7:0] bytes[$];
		logic [7:0] total;
		int unsigned limit;
		int unsigned i;
		limit = tick_limit();
		bytes.push_back(sb.head);
		bytes.push_back(8'(len));
		bytes.push_back(idx);
		bytes.push_back(cmd);
		for (i = 4; i + 1 < len; i++) begin
			bytes.push_back(($urandom_range(0, 3) == 0) ? sb.head : 8'($urandom));
		end
		total = 8'h00;
		foreach (bytes[k]) total = total + bytes[k];
		bytes.push_back(corrupt ? total ^ 8'($urandom_range(1, 255)) : total);
		for (i = 0; i < keep; i++) begin
			if (i > 0 && limit > 1 && $urandom_range(0, 4) == 0) begin
				send_ticks($urandom_range(1, (limit - 1 > 3) ? 3 : limit - 1));
			end
			send_item(MODE_BYTE, bytes[i]);
		end
	endtask

	task automatic random_traffic(input int unsigned budget);
		int unsigned done;
		int unsigned r;
		int unsigned len;
		int unsigned limit;
		int unsigned keep;
		int unsigned n;
		logic [7:0] idx;
		logic [7:0] cmd;
		logic [7:0] bad;
		done = 0;
		limit = tick_limit();
		while (done < budget) begin
			r = $urandom_range(0, 99);
			n = $urandom_range(0, 3);
			len = (n == 0) ? MIN_FRAME_LEN : (n == 1) ? MAX_FRAME_LEN :
				$urandom_range(MIN_FRAME_LEN, MAX_FRAME_LEN);
			idx = $urandom_range(0, 1) ? FIRST_MOTOR_INDEX : 8'($urandom);
			cmd = 8'($urandom);
			if (r < 62) begin
				send_frame(len, idx, cmd, 1'b0, len);
				done += len;
			end else if (r < 72) begin
				send_frame(len, idx, cmd, 1'b1, len);
				done += len;
			end else if (r < 80) begin
				bad = $urandom_range(0, 1) ? 8'($urandom_range(0, MIN_FRAME_LEN - 1)) :
					8'($urandom_range(MAX_FRAME_LEN + 1, 255));
				send_item(MODE_BYTE, sb.head);
				send_item(MODE_BYTE, bad);
				done += 2;
			end else if (r < 86 && limit <= 200) begin
				keep = $urandom_range(1, len - 1);
				send_frame(len, idx, cmd, 1'b0, keep);
				send_ticks(limit + $urandom_range(0, 2));
				done += keep + limit;
			end else if (r < 93) begin
				n = $urandom_range(1, 3);
				repeat (n) send_item(MODE_BYTE, 8'($urandom));
				keep = $urandom_range(0, 3);
				send_ticks(keep);
				done += n + keep;
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) send_item(1'($urandom_range(0, 1)), 8'($urandom));
				done += n;
			end
		end
		if (limit <= 200) begin
			send_ticks(limit);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		settle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.apply_register(idx, data);
		cfg_write <= 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_ticks(1);
		send_item(MODE_BYTE, 8'h00);
		send_frame(MIN_FRAME_LEN, FIRST_MOTOR_INDEX, 8'hFF, 1'b0, MIN_FRAME_LEN);
		send_frame(MAX_FRAME_LEN, sb.head, 8'h00, 1'b0, MAX_FRAME_LEN);
		send_item(MODE_BYTE, sb.head);
		send_item(MODE_BYTE, 8'(MIN_FRAME_LEN - 1));
		send_item(MODE_BYTE, sb.head);
		send_item(MODE_BYTE, 8'(MAX_FRAME_LEN + 1));
		send_frame(MIN_FRAME_LEN, FIRST_MOTOR_INDEX, 8'h3C, 1'b1, MIN_FRAME_LEN);
		random_traffic(120);

		write_register(CFG_HEAD_BYTE, 16'h0000);
		write_register(CFG_TIMEOUT_TICKS, 16'd1);
		send_item(MODE_BYTE, sb.head);
		send_item(MODE_BYTE, 8'd7);
		send_ticks(1);
		random_traffic(120);

		write_register(CFG_HEAD_BYTE, 16'hFFFF);
		write_register(CFG_TIMEOUT_TICKS, 16'hFFFF);
		send_frame(MIN_FRAME_LEN, FIRST_MOTOR_INDEX, 8'h5A, 1'b0, 3);
		send_ticks(40);
		random_traffic(120);

		write_register(CFG_HEAD_BYTE, 16'($urandom));
		write_register(CFG_TIMEOUT_TICKS, 16'd0);
		send_ticks(1);
		send_item(MODE_BYTE, sb.head);
		send_item(MODE_BYTE, 8'd6);
		send_item(MODE_BYTE, FIRST_MOTOR_INDEX);
		send_ticks(1);
		random_traffic(80);

		repeat (2) begin
			write_register(CFG_HEAD_BYTE, 16'($urandom));
			write_register(CFG_TIMEOUT_TICKS, 16'($urandom_range(2, 30)));
			random_traffic(80);
		end

		settle();
		if (sb.errors == 0) begin
			$display("framed_command_receiver: match");
		end else begin
			$display("framed_command_receiver: mismatch");
		end
		$finish;
	end
endmodule

>>> files.f
src/fcr_pkg.sv
src/fcr_frame_fsm.sv
src/framed_command_receiver.sv
bench/tb.sv
